// ----- hw/rtl/lfpd_pkg.sv -----
// Shared constants and types for the line follower PD steering block.
`default_nettype none

package lfpd_pkg;

  // Default sensor sample width.
  localparam int SAMPLE_BITS_DEF = 10;

  // Field widths.
  localparam int POS_W   = 7;   // line position, also the centroid quotient width
  localparam int DUTY_W  = 8;
  localparam int GAIN_W  = 4;
  localparam int ERR_W   = 8;   // position error, two's complement
  localparam int DRV_W   = 14;  // signed drive before saturation

  // Line-lost handling.
  localparam int LOST_THRESHOLD = 50;
  localparam int LOST_RIGHT_POS = 59;
  localparam int LOST_LEFT_POS  = 13;

  // Configuration port.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_LINE_TARGET = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BASE_SPEED  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIN_SPEED   = 3'd5;

  // Settings handed to the drive unit.
  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [DUTY_W-1:0] base_speed;
    logic [DUTY_W-1:0] max_speed;
    logic [DUTY_W-1:0] min_speed;
  } drv_cfg_t;

  // Wheel drive pair.
  typedef struct packed {
    logic [DUTY_W-1:0] right_duty;
    logic [DUTY_W-1:0] left_duty;
    logic              right_reverse;
    logic              left_reverse;
  } drv_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lfpd_div.sv -----
// Radix-2 restoring divider for the weighted centroid, one quotient bit per cycle.
`default_nettype none

module lfpd_div import lfpd_pkg::*; #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [POS_W-1:0] quot_o
);

  localparam int CMP_W = DEN_W + POS_W - 1;
  localparam int CNT_W = $clog2(POS_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CMP_W-1:0] rem_q;
  logic [CMP_W-1:0] dsr_q;
  logic [POS_W-1:0] quot_q;
  logic             ge;

  // Quotient stays below 2^POS_W, so the divisor starts POS_W-1 places up.
  assign ge = (rem_q >= dsr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(POS_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= CMP_W'(num_i);
      dsr_q <= CMP_W'(den_i) << (POS_W - 1);
    end else if (busy_q) begin
      rem_q  <= ge ? (rem_q - dsr_q) : rem_q;
      dsr_q  <= dsr_q >> 1;
      quot_q <= {quot_q[POS_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lfpd_drive.sv -----
// PD wheel drive unit: bit-serial gain multiply, sum, saturate and override.
`default_nettype none

module lfpd_drive import lfpd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ERR_W-1:0] err_i,
  input  logic signed [ERR_W-1:0] prev_i,
  input  drv_cfg_t                cfg_i,
  output logic                    done_o,
  output drv_res_t                res_o
);

  localparam int CNT_W = $clog2(GAIN_W);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_SUM  = 2'd2;
  localparam logic [1:0] D_SAT  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q;
  logic                    done_q;
  logic [GAIN_W-1:0]       kp_q, kd_q;
  logic signed [DRV_W-1:0] mce_q, mcd_q, accp_q, accd_q;
  logic signed [DRV_W-1:0] rv_q, lv_q;
  drv_res_t                res_q, res_d;

  logic signed [ERR_W:0]   delta_w;
  logic signed [DRV_W-1:0] base_s, max_s, min_s, rsat, lsat;

  function automatic logic signed [DRV_W-1:0] sat(input logic signed [DRV_W-1:0] v,
                                                  input logic signed [DRV_W-1:0] mx,
                                                  input logic signed [DRV_W-1:0] mn);
    logic signed [DRV_W-1:0] r;
    priority if (v > mx) r = mx;
    else if (v < mn)     r = mn;
    else                 r = v;
    return r;
  endfunction

  assign delta_w = (ERR_W+1)'(err_i) - (ERR_W+1)'(prev_i);
  assign base_s  = $signed({{(DRV_W-DUTY_W){1'b0}}, cfg_i.base_speed});
  assign max_s   = $signed({{(DRV_W-DUTY_W){1'b0}}, cfg_i.max_speed});
  assign min_s   = $signed({{(DRV_W-DUTY_W){1'b0}}, cfg_i.min_speed});
  assign rsat    = sat(rv_q, max_s, min_s);
  assign lsat    = sat(lv_q, max_s, min_s);

  // Left check first, then the right check on what the left one left.
  always_comb begin
    res_d.right_duty    = rsat[DUTY_W-1:0];
    res_d.left_duty     = lsat[DUTY_W-1:0];
    res_d.right_reverse = 1'b0;
    res_d.left_reverse  = 1'b0;
    if (res_d.left_duty == cfg_i.min_speed) begin
      res_d.left_reverse = 1'b1;
      res_d.left_duty    = cfg_i.base_speed;
      res_d.right_duty   = cfg_i.max_speed;
    end
    if (res_d.right_duty == cfg_i.min_speed) begin
      res_d.right_reverse = 1'b1;
      res_d.right_duty    = cfg_i.base_speed;
      res_d.left_duty     = cfg_i.max_speed;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      D_IDLE:  if (start_i) state_d = D_MUL;
      D_MUL:   if (cnt_q == '0) state_d = D_SUM;
      D_SUM:   state_d = D_SAT;
      D_SAT:   state_d = D_IDLE;
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == D_SAT);
      if (start_i) cnt_q <= CNT_W'(GAIN_W - 1);
      else if (state_q == D_MUL) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mce_q  <= DRV_W'(err_i);
      mcd_q  <= DRV_W'(delta_w);
      kp_q   <= cfg_i.prop_gain;
      kd_q   <= cfg_i.deriv_gain;
      accp_q <= '0;
      accd_q <= '0;
    end else if (state_q == D_MUL) begin
      // Take one gain bit a cycle, lowest first.
      if (kp_q[0]) accp_q <= accp_q + mce_q;
      if (kd_q[0]) accd_q <= accd_q + mcd_q;
      mce_q <= mce_q <<< 1;
      mcd_q <= mcd_q <<< 1;
      kp_q  <= kp_q >> 1;
      kd_q  <= kd_q >> 1;
    end
    if (state_q == D_SUM) begin
      rv_q <= base_s + accp_q + accd_q;
      lv_q <= base_s - accp_q + accd_q;
    end
    if (state_q == D_SAT) res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/line_follow_pd_steering.sv -----
// Top level of the PD steering block for a three-sensor line follower.
//
//  Channel   Direction  Payload (lowest bits first)
//  s_axis    in         left_sample, middle_sample, right_sample
//  m_axis    out        tdata: right_duty, left_duty, right_reverse, left_reverse,
//                       line_position; tuser: line_lost
//  apb       in/out     six settings registers at byte addresses 0x00..0x14
//
//  A tracked line passes through capture, scale, the serial divider (seven
//  quotient bits and a done flag), error update, the drive unit (four gain-bit
//  multiply steps, sum, saturation, done) and the output. A lost line goes from
//  scale straight to the output. Reset is asynchronous and active low; it restores
//  the register defaults and clears the stored error and side. A stalled result
//  waits in the output register while the next item is already being worked on.
`default_nettype none

module line_follow_pd_steering import lfpd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_W = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // left_sample, middle_sample, right_sample
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,
  // right_duty, left_duty, right_reverse, left_reverse, line_position
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,
  // line_lost
  output logic [0:0]            m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SUM_W = SAMPLE_BITS + 2;
  localparam int T_W   = SAMPLE_BITS + 4;
  localparam int NUM_W = SAMPLE_BITS + 7;
  localparam int OUT_FIELDS_W = 2 * DUTY_W + 2 + POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_ERR   = 3'd3;
  localparam logic [2:0] S_DRV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // Settings registers.
  logic [POS_W-1:0]  target_q;
  logic [GAIN_W-1:0] kp_q, kd_q;
  logic [DUTY_W-1:0] base_q, max_q, min_q;

  logic [2:0]              state_q, state_d;
  logic signed [ERR_W-1:0] prev_q;
  logic                    side_right_q;
  logic                    m_valid_q;

  logic [SUM_W-1:0] tot_q;
  logic [T_W-1:0]   wsum_q;
  logic [POS_W-1:0] pos_q;
  logic             lost_q;
  drv_res_t         res_q;
  drv_res_t         out_res_q;
  logic [POS_W-1:0] out_pos_q;
  logic             out_lost_q;

  logic [SAMPLE_BITS-1:0]  left_w, middle_w, right_w;
  logic                    in_fire, is_lost, out_load, wr_en;
  logic [NUM_W-1:0]        num_w;
  logic signed [ERR_W-1:0] err_w;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    div_start, div_done, drv_start, drv_done;
  logic [POS_W-1:0]        quot_w;
  drv_cfg_t                drv_cfg;
  drv_res_t                drv_res, lost_res;

  assign left_w   = s_axis_tdata[SAMPLE_BITS-1:0];
  assign middle_w = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign right_w  = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_lost       = (tot_q < SUM_W'(LOST_THRESHOLD));
  assign out_load      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  // Weights 10, 40, 70 share a factor ten: numerator = 10 * (l + 4m + 7r).
  assign num_w = (NUM_W'(wsum_q) << 3) + (NUM_W'(wsum_q) << 1);
  assign err_w = $signed(ERR_W'(target_q) - ERR_W'(pos_q));

  assign div_start = (state_q == S_SCALE) && !is_lost;
  assign drv_start = (state_q == S_ERR);

  assign drv_cfg.prop_gain  = kp_q;
  assign drv_cfg.deriv_gain = kd_q;
  assign drv_cfg.base_speed = base_q;
  assign drv_cfg.max_speed  = max_q;
  assign drv_cfg.min_speed  = min_q;

  // Pivot toward the last side seen, inner wheel reversed at half speed.
  always_comb begin
    if (side_right_q) begin
      lost_res.right_duty    = base_q;
      lost_res.left_duty     = base_q >> 1;
      lost_res.right_reverse = 1'b0;
      lost_res.left_reverse  = 1'b1;
    end else begin
      lost_res.right_duty    = base_q >> 1;
      lost_res.left_duty     = base_q;
      lost_res.right_reverse = 1'b1;
      lost_res.left_reverse  = 1'b0;
    end
  end

  lfpd_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_w),
    .den_i   (tot_q),
    .done_o  (div_done),
    .quot_o  (quot_w)
  );

  lfpd_drive u_drive (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (drv_start),
    .err_i   (err_w),
    .prev_i  (prev_q),
    .cfg_i   (drv_cfg),
    .done_o  (drv_done),
    .res_o   (drv_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_SCALE;
      S_SCALE: state_d = is_lost ? S_OUT : S_DIV;
      S_DIV:   if (div_done) state_d = S_ERR;
      S_ERR:   state_d = S_DRV;
      S_DRV:   if (drv_done) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Configuration port: write on the access cycle, read back any time.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_LINE_TARGET: prdata = APB_DATA_W'(target_q);
      REG_PROP_GAIN:   prdata = APB_DATA_W'(kp_q);
      REG_DERIV_GAIN:  prdata = APB_DATA_W'(kd_q);
      REG_BASE_SPEED:  prdata = APB_DATA_W'(base_q);
      REG_MAX_SPEED:   prdata = APB_DATA_W'(max_q);
      REG_MIN_SPEED:   prdata = APB_DATA_W'(min_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= POS_W'(40);
      kp_q         <= GAIN_W'(1);
      kd_q         <= '0;
      base_q       <= DUTY_W'(128);
      max_q        <= DUTY_W'(255);
      min_q        <= '0;
      state_q      <= S_IDLE;
      prev_q       <= '0;
      side_right_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        unique case (reg_idx)
          REG_LINE_TARGET: target_q <= pwdata[POS_W-1:0];
          REG_PROP_GAIN:   kp_q     <= pwdata[GAIN_W-1:0];
          REG_DERIV_GAIN:  kd_q     <= pwdata[GAIN_W-1:0];
          REG_BASE_SPEED:  base_q   <= pwdata[DUTY_W-1:0];
          REG_MAX_SPEED:   max_q    <= pwdata[DUTY_W-1:0];
          REG_MIN_SPEED:   min_q    <= pwdata[DUTY_W-1:0];
          default: ;
        endcase
      end
      // Advance the stored error; keep the side on a zero error.
      if (state_q == S_ERR) begin
        prev_q <= err_w;
        if (err_w < 0)      side_right_q <= 1'b0;
        else if (err_w > 0) side_right_q <= 1'b1;
      end
      if (out_load)                        m_valid_q <= 1'b1;
      else if (m_axis_tready)              m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tot_q  <= SUM_W'(left_w) + SUM_W'(middle_w) + SUM_W'(right_w);
      wsum_q <= T_W'(left_w) + (T_W'(middle_w) << 2) + (T_W'(right_w) << 3)
                - T_W'(right_w);
    end
    if (state_q == S_SCALE) begin
      lost_q <= is_lost;
      if (is_lost) begin
        res_q <= lost_res;
        pos_q <= side_right_q ? POS_W'(LOST_RIGHT_POS) : POS_W'(LOST_LEFT_POS);
      end
    end
    if ((state_q == S_DIV) && div_done) pos_q <= quot_w;
    if ((state_q == S_DRV) && drv_done) res_q <= drv_res;
    if (out_load) begin
      out_res_q  <= res_q;
      out_pos_q  <= pos_q;
      out_lost_q <= lost_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(32-OUT_FIELDS_W){1'b0}}, out_pos_q,
                          out_res_q.left_reverse, out_res_q.right_reverse,
                          out_res_q.left_duty, out_res_q.right_duty};
  assign m_axis_tuser  = out_lost_q;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide phase");

  a_drv_done_in_drv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drv_done |-> (state_q == S_DRV))
    else $error("drive unit finished outside the drive phase");

  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result presented without passing the output phase");

  a_tracked_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !out_lost_q) |-> ((out_pos_q >= POS_W'(10)) && (out_pos_q <= POS_W'(70))))
    else $error("centroid outside the sensor span");

  a_lost_pos_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_lost_q) |->
      ((out_pos_q == POS_W'(LOST_RIGHT_POS)) || (out_pos_q == POS_W'(LOST_LEFT_POS))))
    else $error("lost-line position is neither side code");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the line follower PD steering block.
`timescale 1ns / 100ps

module tb_top;
  import lfpd_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int IN_W         = ((3 * SB + 7) / 8) * 8;
  localparam int WEIGHT_L     = 10;
  localparam int WEIGHT_M     = 40;
  localparam int WEIGHT_R     = 70;
  localparam int TAIL_CYCLES  = 25;      // settle time after the last result
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 235;

  // One wheel drive result as the block should report it.
  typedef struct packed {
    logic [DUTY_W-1:0] right_duty;
    logic [DUTY_W-1:0] left_duty;
    logic              right_reverse;
    logic              left_reverse;
    logic              line_lost;
    logic [POS_W-1:0]  line_position;
  } steer_t;

  // Receiver stall patterns.
  typedef enum int {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // left_sample, middle_sample, right_sample, zero padding
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // right_duty, left_duty, right_reverse, left_reverse, line_position
  logic [31:0]           m_axis_tdata;
  // line_lost
  logic [0:0]            m_axis_tuser;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor copy of the settings registers, at their reset values.
  logic [POS_W-1:0]  cfg_target = POS_W'(40);
  logic [GAIN_W-1:0] cfg_kp     = GAIN_W'(1);
  logic [GAIN_W-1:0] cfg_kd     = '0;
  logic [DUTY_W-1:0] cfg_base   = DUTY_W'(128);
  logic [DUTY_W-1:0] cfg_max    = DUTY_W'(255);
  logic [DUTY_W-1:0] cfg_min    = '0;

  // Predictor copy of the steering state.
  logic signed [ERR_W-1:0] last_error = '0;
  logic                    side_right = 1'b0;

  steer_t   pending_drives[$];
  int       mismatches  = 0;
  int       cycle_count = 0;
  int       burst_left  = 0;
  bit       sender_gaps = 1'b1;
  rx_mode_e rx_mode     = RX_ALWAYS;
  bit       hold_req    = 1'b0;
  int       hold_left   = 0;
  int       rx_tick     = 0;

  line_follow_pd_steering #(.SAMPLE_BITS(SB)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Give up well past the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Saturate a drive: the upper limit wins, only otherwise clamp to the lower.
  function automatic int clamp_duty(int v);
    if (v > int'(cfg_max)) return int'(cfg_max);
    if (v < int'(cfg_min)) return int'(cfg_min);
    return v;
  endfunction

  // Work out the wheel drives for one sample triple and advance the state.
  function automatic steer_t predict_steer(logic [SB-1:0] l, logic [SB-1:0] m,
                                           logic [SB-1:0] r);
    int     total, pos, err, delta, rv, lv;
    steer_t d;
    d     = '0;
    total = int'(l) + int'(m) + int'(r);
    if (total < LOST_THRESHOLD) begin
      // Line lost: pivot towards the last side seen, state left alone.
      d.line_lost = 1'b1;
      if (side_right) begin
        d.line_position = POS_W'(LOST_RIGHT_POS);
        d.right_duty    = cfg_base;
        d.left_duty     = cfg_base >> 1;
        d.left_reverse  = 1'b1;
      end else begin
        d.line_position = POS_W'(LOST_LEFT_POS);
        d.right_duty    = cfg_base >> 1;
        d.left_duty     = cfg_base;
        d.right_reverse = 1'b1;
      end
      return d;
    end
    pos = (WEIGHT_L * int'(l) + WEIGHT_M * int'(m) + WEIGHT_R * int'(r)) / total;
    err = int'(cfg_target) - pos;
    // A zero error keeps the side seen last.
    if (err < 0) side_right = 1'b0;
    else if (err > 0) side_right = 1'b1;
    delta      = err - int'(last_error);
    last_error = ERR_W'(err);
    rv = clamp_duty(int'(cfg_base) + int'(cfg_kp) * err + int'(cfg_kd) * delta);
    lv = clamp_duty(int'(cfg_base) - int'(cfg_kp) * err + int'(cfg_kd) * delta);
    // Left wheel at its floor first, then the right one on what that left behind.
    if (lv == int'(cfg_min)) begin
      d.left_reverse = 1'b1;
      lv = int'(cfg_base);
      rv = int'(cfg_max);
    end
    if (rv == int'(cfg_min)) begin
      d.right_reverse = 1'b1;
      rv = int'(cfg_base);
      lv = int'(cfg_max);
    end
    d.right_duty    = DUTY_W'(rv);
    d.left_duty     = DUTY_W'(lv);
    d.line_position = POS_W'(pos);
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result with the oldest outstanding drive.
  always @(posedge clk_i) begin : check_results
    steer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_drives.size() == 0) begin
        $error("result with no item outstanding: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_drives.pop_front();
        check_field("right_duty", want.right_duty, m_axis_tdata[DUTY_W-1:0]);
        check_field("left_duty", want.left_duty, m_axis_tdata[2*DUTY_W-1:DUTY_W]);
        check_field("right_reverse", want.right_reverse, m_axis_tdata[2*DUTY_W]);
        check_field("left_reverse", want.left_reverse, m_axis_tdata[2*DUTY_W+1]);
        check_field("line_position", want.line_position,
                    m_axis_tdata[2*DUTY_W+2 +: POS_W]);
        check_field("line_lost", want.line_lost, m_axis_tuser[0]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on the current pattern, or hold off for a long stretch
  // when a test asks for it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rx_tick++;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_LIGHT:  m_axis_tready <= ($urandom_range(3, 0) != 0);
        RX_HEAVY:  m_axis_tready <= 1'($urandom_range(1, 0));
        default:   m_axis_tready <= ((rx_tick % 8) < 5);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and register access
  // ---------------------------------------------------------------------------

  // Offer one item, idling before it at the start of each burst when gaps are on,
  // and hold until it is taken. Leave tvalid high so the next item can follow at once.
  task automatic send_item(logic [SB-1:0] l, logic [SB-1:0] m, logic [SB-1:0] r);
    int gap;
    gap = 0;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        gap        = $urandom_range(24, 1);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - 3 * SB){1'b0}}, r, m, l};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_drives.push_back(predict_steer(l, m, r));
  endtask

  // Drop tvalid, wait for every outstanding result, then let the block settle.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Write one register, mirror it into the predictor and read it back.
  task automatic apb_write(logic [REG_IDX_W-1:0] idx, int value);
    logic [APB_DATA_W-1:0] stored;
    stored = '0;
    case (idx)
      REG_LINE_TARGET: begin
        cfg_target = POS_W'(value);
        stored     = APB_DATA_W'(cfg_target);
      end
      REG_PROP_GAIN: begin
        cfg_kp = GAIN_W'(value);
        stored = APB_DATA_W'(cfg_kp);
      end
      REG_DERIV_GAIN: begin
        cfg_kd = GAIN_W'(value);
        stored = APB_DATA_W'(cfg_kd);
      end
      REG_BASE_SPEED: begin
        cfg_base = DUTY_W'(value);
        stored   = APB_DATA_W'(cfg_base);
      end
      REG_MAX_SPEED: begin
        cfg_max = DUTY_W'(value);
        stored  = APB_DATA_W'(cfg_max);
      end
      REG_MIN_SPEED: begin
        cfg_min = DUTY_W'(value);
        stored  = APB_DATA_W'(cfg_min);
      end
      default: ;
    endcase
    // Setup then access phase for the write.
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= stored;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // Read back the same register.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", int'(stored), int'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    // Leave the bus idle before the next transfer.
    @(posedge clk_i);
  endtask

  // Bring the block to idle and load a full set of steering settings.
  task automatic set_steering(int target, int kp, int kd, int base, int max_d,
                              int min_d);
    wait_for_drain();
    apb_write(REG_LINE_TARGET, target);
    apb_write(REG_PROP_GAIN, kp);
    apb_write(REG_DERIV_GAIN, kd);
    apb_write(REG_BASE_SPEED, base);
    apb_write(REG_MAX_SPEED, max_d);
    apb_write(REG_MIN_SPEED, min_d);
  endtask

  // Pick a register value, favouring the ends of its range.
  function automatic int pick_extreme(int hi);
    int k;
    k = $urandom_range(7, 0);
    if (k == 0) return 0;
    if (k == 1) return hi;
    return $urandom_range(hi, 0);
  endfunction

  // Draw a sample triple: lost lines, sums near the threshold, one sensor
  // dominant, or fully random.
  task automatic random_samples(output logic [SB-1:0] l, output logic [SB-1:0] m,
                                output logic [SB-1:0] r);
    int kind, a, b, c, t, which;
    kind = $urandom_range(99, 0);
    if (kind < 15) begin
      a = $urandom_range(LOST_THRESHOLD - 1, 0);
      b = $urandom_range(LOST_THRESHOLD - 1 - a, 0);
      c = $urandom_range(LOST_THRESHOLD - 1 - a - b, 0);
    end else if (kind < 25) begin
      t = $urandom_range(LOST_THRESHOLD + 5, LOST_THRESHOLD - 5);
      a = $urandom_range(t, 0);
      b = $urandom_range(t - a, 0);
      c = t - a - b;
    end else if (kind < 45) begin
      which = $urandom_range(2, 0);
      a = (which == 0) ? $urandom_range((1 << SB) - 1, 0) : $urandom_range(15, 0);
      b = (which == 1) ? $urandom_range((1 << SB) - 1, 0) : $urandom_range(15, 0);
      c = (which == 2) ? $urandom_range((1 << SB) - 1, 0) : $urandom_range(15, 0);
    end else begin
      a = $urandom_range((1 << SB) - 1, 0);
      b = $urandom_range((1 << SB) - 1, 0);
      c = $urandom_range((1 << SB) - 1, 0);
    end
    l = SB'(a);
    m = SB'(b);
    r = SB'(c);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: sample extremes, both lost sides and the lost threshold.
  task automatic test_default_settings();
    rx_mode     = RX_ALWAYS;
    sender_gaps = 1'b0;
    send_item('0, '0, '0);                     // lost, nothing seen yet: left
    send_item('1, '0, '0);                     // far left, line to the right
    send_item('0, '0, '0);                     // lost, right side remembered
    send_item('0, '0, '1);                     // far right
    send_item('1, '1, '1);                     // centred, zero error
    send_item(SB'(49), '0, '0);                // one below the threshold
    send_item(SB'(50), '0, '0);                // exactly at the threshold
    send_item('0, SB'(24), SB'(25));
    send_item(SB'(10'h2AA), SB'(10'h155), SB'(10'h2AA));
    send_item(SB'(10'h155), SB'(10'h2AA), SB'(10'h155));
  endtask

  // Register extremes: saturation both ways, inverted limits and both floors.
  task automatic test_register_extremes();
    set_steering(127, 15, 15, 255, 255, 0);
    send_item('0, '1, '0);
    send_item('1, '0, '0);
    set_steering(0, 15, 0, 0, 255, 0);        // right wheel pinned at the floor
    send_item('0, '0, '1);
    send_item('1, '0, '0);
    set_steering(40, 3, 7, 100, 0, 255);      // upper limit below the lower one
    send_item('1, '0, '0);
    send_item('0, '0, '1);
    set_steering(40, 4, 2, 128, 200, 60);
    send_item('1, '0, '0);                     // right drive clamps to the upper limit
    send_item('0, '0, '1);                     // right drive clamps to the floor
    send_item('0, '1, '0);
    set_steering(40, 0, 0, 60, 60, 60);       // both wheels sit on the floor
    send_item('0, '1, '0);
  endtask

  // Hold the receiver off while the sender keeps offering, so the block fills
  // and stalls its input.
  task automatic test_output_holdoff();
    set_steering(40, 2, 1, 128, 255, 0);
    rx_mode     = RX_ALWAYS;
    sender_gaps = 1'b0;
    hold_req    = 1'b1;
    for (int i = 0; i < 40; i++) begin
      logic [SB-1:0] l, m, r;
      random_samples(l, m, r);
      send_item(l, m, r);
    end
  endtask

  // Random samples over several settings and idling patterns; pause the
  // sender mid-phase until every outstanding result has come.
  task automatic test_random_traffic();
    logic [SB-1:0] l, m, r;
    int            target, min_d, max_d;
    for (int p = 0; p < PHASES; p++) begin
      target = ($urandom_range(3, 0) == 0) ? pick_extreme((1 << POS_W) - 1)
                                           : $urandom_range(70, 10);
      min_d  = ($urandom_range(3, 0) == 0) ? pick_extreme(255) : $urandom_range(90, 0);
      max_d  = ($urandom_range(3, 0) == 0) ? pick_extreme(255)
                                           : $urandom_range(255, 160);
      set_steering(target, pick_extreme(15), pick_extreme(15), pick_extreme(255),
                   max_d, min_d);
      rx_mode     = rx_mode_e'(p % 4);
      sender_gaps = (p % 3 != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) wait_for_drain();
        random_samples(l, m, r);
        send_item(l, m, r);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_settings();
    test_register_extremes();
    test_output_holdoff();
    test_random_traffic();
    wait_for_drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lfpd_pkg.sv
hw/rtl/lfpd_div.sv
hw/rtl/lfpd_drive.sv
hw/rtl/line_follow_pd_steering.sv
tb/sv/tb_top.sv
